[hdl/m68k_ilc_pkg.sv]
package m68k_ilc_pkg;

    localparam int AddrWidth  = 24;
    localparam int ImageWidth = 25;
    localparam int WordWidth  = 16;

    localparam logic [ImageWidth-1:0] ImageSizeReset = 25'h1000000;
    localparam logic [31:0]           NoTarget       = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        TERM_NONE     = 4'd0,
        TERM_BRA      = 4'd1,
        TERM_BCC      = 4'd2,
        TERM_BSR      = 4'd3,
        TERM_DBCC     = 4'd4,
        TERM_JMP_ABS  = 4'd5,
        TERM_JSR_ABS  = 4'd6,
        TERM_JMP_PC   = 4'd7,
        TERM_JSR_PC   = 4'd8,
        TERM_JMP_IND  = 4'd9,
        TERM_JSR_IND  = 4'd10,
        TERM_RTS      = 4'd11,
        TERM_RTR      = 4'd12,
        TERM_RTE      = 4'd13,
        TERM_STOP     = 4'd14,
        TERM_UNCL     = 4'd15
    } term_t;

    typedef enum logic [2:0] {
        KIND_ABS_W = 3'd0,
        KIND_ABS_L = 3'd1,
        KIND_PCREL = 3'd2,
        KIND_IMM_L = 3'd3,
        KIND_IMM_W = 3'd4
    } kind_t;

    typedef struct packed {
        logic [4:0]  length_bytes;
        term_t       term_class;
        logic [31:0] static_target;
        logic [2:0]  jump_mode;
        logic [2:0]  jump_reg;
        logic [1:0]  record_count;
        logic [3:0]  rec0_offset;
        kind_t       rec0_kind;
        logic        rec0_is_dest;
        logic [3:0]  rec1_offset;
        kind_t       rec1_kind;
        logic        rec1_is_dest;
    } ilc_result_t;

endpackage

[hdl/m68k_instruction_length_classifier.sv]
// An accepted input beat is held in the input register, decoded, and loaded into the
// result register, from which it is presented; out_stall can hold it in between.
// Throughput: one instruction per cycle while out_stall stays low; the input register and the result
// register form a two-stage pipeline with one combinational decode between them.
// Reset (rst_n low, asynchronous) empties both stages and sets image_size to
// 16 MiB; no clearing pass is needed.
module m68k_instruction_length_classifier
    import m68k_ilc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [ImageWidth-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [AddrWidth-1:0]  pc,
    input  logic [WordWidth-1:0]  word0,
    input  logic [WordWidth-1:0]  word1,
    input  logic [WordWidth-1:0]  word2,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [4:0]            length_bytes,
    output logic [3:0]            term_class,
    output logic [31:0]           static_target,
    output logic [2:0]            jump_mode,
    output logic [2:0]            jump_reg,
    output logic [1:0]            record_count,
    output logic [3:0]            rec0_offset,
    output logic [2:0]            rec0_kind,
    output logic                  rec0_is_dest,
    output logic [3:0]            rec1_offset,
    output logic [2:0]            rec1_kind,
    output logic                  rec1_is_dest
);

    logic [ImageWidth-1:0] image_size_reg;
    logic [ImageWidth-1:0] image_size_next;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [AddrWidth-1:0]  pc_reg;
    logic [WordWidth-1:0]  word0_reg;
    logic [WordWidth-1:0]  word1_reg;
    logic [WordWidth-1:0]  word2_reg;
    ilc_result_t           decoded;
    ilc_result_t           result_reg;
    logic                  in_take;
    logic                  out_load;

    m68k_ilc_decode u_decode (
        .pc         (pc_reg),
        .word0      (word0_reg),
        .word1      (word1_reg),
        .word2      (word2_reg),
        .image_size (image_size_reg),
        .result     (decoded)
    );

    // The result register takes a new beat whenever it is empty or its beat is leaving.
    assign out_load  = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !out_load;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        image_size_next = image_size_reg;
        if (cfg_valid && cfg_ready) begin
            image_size_next = cfg_data;
        end
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end
        else if (out_load) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_load ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            image_size_reg <= ImageSizeReset;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            image_size_reg <= image_size_next;
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            pc_reg    <= pc;
            word0_reg <= word0;
            word1_reg <= word1;
            word2_reg <= word2;
        end
        if (out_load && in_valid_reg) begin
            result_reg <= decoded;
        end
    end

    assign out_valid     = out_valid_reg;
    assign length_bytes  = result_reg.length_bytes;
    assign term_class    = result_reg.term_class;
    assign static_target = result_reg.static_target;
    assign jump_mode     = result_reg.jump_mode;
    assign jump_reg      = result_reg.jump_reg;
    assign record_count  = result_reg.record_count;
    assign rec0_offset   = result_reg.rec0_offset;
    assign rec0_kind     = result_reg.rec0_kind;
    assign rec0_is_dest  = result_reg.rec0_is_dest;
    assign rec1_offset   = result_reg.rec1_offset;
    assign rec1_kind     = result_reg.rec1_kind;
    assign rec1_is_dest  = result_reg.rec1_is_dest;

endmodule

[hdl/m68k_ilc_decode.sv]
module m68k_ilc_decode
    import m68k_ilc_pkg::*;
(
    input  logic [AddrWidth-1:0]  pc,
    input  logic [WordWidth-1:0]  word0,
    input  logic [WordWidth-1:0]  word1,
    input  logic [WordWidth-1:0]  word2,
    input  logic [ImageWidth-1:0] image_size,
    output ilc_result_t           result
);

    localparam logic [3:0] LINE_BITOP  = 4'h0;
    localparam logic [3:0] LINE_MOVEB  = 4'h1;
    localparam logic [3:0] LINE_MOVEL  = 4'h2;
    localparam logic [3:0] LINE_MOVEW  = 4'h3;
    localparam logic [3:0] LINE_MISC   = 4'h4;
    localparam logic [3:0] LINE_QUICK  = 4'h5;
    localparam logic [3:0] LINE_BRANCH = 4'h6;
    localparam logic [3:0] LINE_MOVEQ  = 4'h7;
    localparam logic [3:0] LINE_OR     = 4'h8;
    localparam logic [3:0] LINE_SUB    = 4'h9;
    localparam logic [3:0] LINE_CMP    = 4'hB;
    localparam logic [3:0] LINE_AND    = 4'hC;
    localparam logic [3:0] LINE_ADD    = 4'hD;
    localparam logic [3:0] LINE_SHIFT  = 4'hE;

    localparam logic [15:0] OP_JSR   = 16'h4E80;
    localparam logic [15:0] OP_JMP   = 16'h4EC0;
    localparam logic [15:0] OP_RTS   = 16'h4E75;
    localparam logic [15:0] OP_RTR   = 16'h4E77;
    localparam logic [15:0] OP_RTE   = 16'h4E73;
    localparam logic [15:0] OP_RESET = 16'h4E70;
    localparam logic [15:0] OP_TRAPV = 16'h4E76;
    localparam logic [15:0] OP_ILLEG = 16'h4AFC;
    localparam logic [15:0] OP_STOP  = 16'h4E72;
    localparam logic [15:0] OP_RTD   = 16'h4E74;
    localparam logic [15:0] OP_NOP   = 16'h4E71;
    localparam logic [15:0] OP_SWAP  = 16'h4840;
    localparam logic [15:0] OP_EXTW  = 16'h4880;
    localparam logic [15:0] OP_EXTL  = 16'h48C0;
    localparam logic [15:0] OP_EXTB  = 16'h49C0;
    localparam logic [15:0] OP_LEA   = 16'h41C0;
    localparam logic [15:0] OP_PEA   = 16'h4840;
    localparam logic [15:0] OP_NBCD  = 16'h4800;
    localparam logic [15:0] OP_CHK   = 16'h4100;
    localparam logic [15:0] OP_LINK  = 16'h4E50;
    localparam logic [15:0] OP_UNLK  = 16'h4E58;
    localparam logic [15:0] OP_TRAP  = 16'h4E40;
    localparam logic [15:0] OP_MUSP  = 16'h4E60;
    localparam logic [15:0] OP_DBCC  = 16'h50C8;
    localparam logic [15:0] OP_SCC   = 16'h50C0;
    localparam logic [15:0] MASK_HI  = 16'hFFC0;
    localparam logic [15:0] MASK_LO3 = 16'hFFF8;
    localparam logic [15:0] MASK_LEA = 16'hF1C0;
    localparam logic [15:0] MASK_CHK = 16'hF140;
    localparam logic [15:0] MASK_DBC = 16'hF0F8;
    localparam logic [15:0] MASK_SCC = 16'hF0C0;
    localparam logic [15:0] MASK_TRP = 16'hFFF0;
    localparam logic [15:0] MASK_MVM = 16'hFB80;

    typedef struct packed {
        logic       valid;
        logic [3:0] offset;
        kind_t      kind;
        logic       is_dest;
    } rec_t;

    function automatic logic [1:0] ext_words(input logic [2:0] mode, input logic [2:0] ea_reg,
                                             input logic is_long);
        logic [1:0] n;
        n = 2'd0;
        if (mode == 3'd5 || mode == 3'd6) begin
            n = 2'd1;
        end
        else if (mode == 3'd7) begin
            case (ea_reg)
                3'd0:    n = 2'd1;
                3'd1:    n = 2'd2;
                3'd2:    n = 2'd1;
                3'd3:    n = 2'd1;
                3'd4:    n = is_long ? 2'd2 : 2'd1;
                default: n = 2'd0;
            endcase
        end
        return n;
    endfunction

    function automatic rec_t note(input logic [2:0] mode, input logic [2:0] ea_reg,
                                  input logic [3:0] offset, input logic is_dest);
        rec_t r;
        r = '{valid: 1'b0, offset: 4'd0, kind: KIND_ABS_W, is_dest: 1'b0};
        if (mode == 3'd7) begin
            if (ea_reg == 3'd0 || ea_reg == 3'd1) begin
                r.valid   = 1'b1;
                r.offset  = offset;
                r.kind    = (ea_reg == 3'd0) ? KIND_ABS_W : KIND_ABS_L;
                r.is_dest = is_dest;
            end
            else if (ea_reg == 3'd2) begin
                r.valid  = 1'b1;
                r.offset = offset;
                r.kind   = KIND_PCREL;
            end
        end
        return r;
    endfunction

    logic [ImageWidth-1:0] end0;
    logic [ImageWidth-1:0] end1;
    logic [ImageWidth-1:0] end2;
    logic [15:0]           w0;
    logic [15:0]           w1;
    logic [15:0]           w2;
    logic [3:0]            op;
    logic [2:0]            mode;
    logic [2:0]            ea_reg;
    logic [2:0]            dmode;
    logic [2:0]            dreg;
    logic [1:0]            sz;
    logic                  is_long;
    logic                  imm_ea;
    logic [1:0]            se;
    logic [2:0]            ext;
    term_t                 term;
    logic                  has_target;
    logic                  rel_target;
    logic [23:0]           disp;
    logic [23:0]           abs_target;
    logic [23:0]           rel_sum;
    logic [2:0]            jmode;
    logic [2:0]            jreg;
    rec_t                  rec_a;
    rec_t                  rec_b;
    rec_t                  out0;
    rec_t                  out1;

    assign end0 = {1'b0, pc} + 25'd1;
    assign end1 = {1'b0, pc} + 25'd3;
    assign end2 = {1'b0, pc} + 25'd5;
    assign w0   = (end0 >= image_size) ? 16'hFFFF : word0;
    assign w1   = (end1 >= image_size) ? 16'hFFFF : word1;
    assign w2   = (end2 >= image_size) ? 16'hFFFF : word2;

    assign op     = w0[15:12];
    assign mode   = w0[5:3];
    assign ea_reg = w0[2:0];
    assign dmode  = w0[8:6];
    assign dreg   = w0[11:9];
    assign sz     = w0[7:6];
    assign imm_ea = (mode == 3'd7) && (ea_reg == 3'd4);

    always_comb
    begin
        ext        = 3'd0;
        term       = TERM_NONE;
        has_target = 1'b0;
        rel_target = 1'b0;
        disp       = 24'd0;
        abs_target = 24'd0;
        jmode      = 3'd0;
        jreg       = 3'd0;
        is_long    = 1'b0;
        se         = 2'd0;
        rec_a      = '{valid: 1'b0, offset: 4'd0, kind: KIND_ABS_W, is_dest: 1'b0};
        rec_b      = '{valid: 1'b0, offset: 4'd0, kind: KIND_ABS_W, is_dest: 1'b0};
        case (op)
            LINE_BITOP:
            begin
                if (w0[8]) begin
                    if (mode == 3'd1) begin
                        ext = 3'd1;
                    end
                    else begin
                        rec_a = note(mode, ea_reg, 4'd2, 1'b0);
                        ext   = {1'b0, ext_words(mode, ea_reg, 1'b0)};
                    end
                end
                else if (w0[11:9] == 3'd4) begin
                    if (imm_ea) begin
                        ext = 3'd1;
                    end
                    else begin
                        rec_a = note(mode, ea_reg, 4'd4, 1'b0);
                        ext   = 3'd1 + {1'b0, ext_words(mode, ea_reg, 1'b0)};
                    end
                end
                else begin
                    is_long = (sz == 2'd2);
                    if (imm_ea) begin
                        ext = is_long ? 3'd2 : 3'd1;
                    end
                    else begin
                        rec_a = note(mode, ea_reg, is_long ? 4'd6 : 4'd4, 1'b0);
                        ext   = (is_long ? 3'd2 : 3'd1)
                              + {1'b0, ext_words(mode, ea_reg, is_long)};
                    end
                end
            end
            LINE_MOVEB, LINE_MOVEL, LINE_MOVEW:
            begin
                is_long = (op == LINE_MOVEL);
                se      = ext_words(mode, ea_reg, is_long);
                rec_a   = note(mode, ea_reg, 4'd2, 1'b0);
                if (op != LINE_MOVEB && dmode == 3'd1 && imm_ea) begin
                    rec_a = '{valid: 1'b1, offset: 4'd2,
                              kind: is_long ? KIND_IMM_L : KIND_IMM_W, is_dest: 1'b0};
                end
                rec_b = note(dmode, dreg, 4'd2 + {1'b0, se, 1'b0}, 1'b1);
                ext   = {1'b0, se} + {1'b0, ext_words(dmode, dreg, is_long)};
            end
            LINE_MISC:
            begin
                if ((w0 & MASK_HI) == OP_JSR || (w0 & MASK_HI) == OP_JMP) begin
                    jmode = mode;
                    jreg  = ea_reg;
                    if (mode == 3'd7 && (ea_reg == 3'd0 || ea_reg == 3'd1)) begin
                        has_target = 1'b1;
                        abs_target = (ea_reg == 3'd0) ? {{8{w1[15]}}, w1} : {w1[7:0], w2};
                        term       = w0[6] ? TERM_JMP_ABS : TERM_JSR_ABS;
                    end
                    else if (mode == 3'd7 && (ea_reg == 3'd2 || ea_reg == 3'd3)) begin
                        term = w0[6] ? TERM_JMP_PC : TERM_JSR_PC;
                    end
                    else begin
                        term = w0[6] ? TERM_JMP_IND : TERM_JSR_IND;
                    end
                    ext = {1'b0, ext_words(mode, ea_reg, 1'b1)};
                end
                else if (w0 == OP_RTS) begin
                    term = TERM_RTS;
                end
                else if (w0 == OP_RTR) begin
                    term = TERM_RTR;
                end
                else if (w0 == OP_RTE) begin
                    term = TERM_RTE;
                end
                else if (w0 == OP_RESET || w0 == OP_TRAPV || w0 == OP_ILLEG) begin
                    term = TERM_STOP;
                end
                else if (w0 == OP_STOP || w0 == OP_RTD) begin
                    term = TERM_STOP;
                    ext  = 3'd1;
                end
                else if (w0 == OP_NOP) begin
                    ext = 3'd0;
                end
                else if ((w0 & MASK_LO3) == OP_SWAP || (w0 & MASK_LO3) == OP_EXTW
                         || (w0 & MASK_LO3) == OP_EXTL || (w0 & MASK_LO3) == OP_EXTB) begin
                    ext = 3'd0;
                end
                else if ((w0 & MASK_LEA) == OP_LEA || (w0 & MASK_HI) == OP_PEA) begin
                    rec_a = note(mode, ea_reg, 4'd2, 1'b0);
                    ext   = {1'b0, ext_words(mode, ea_reg, 1'b1)};
                end
                else if ((w0 & MASK_MVM) == OP_EXTW) begin
                    rec_a = note(mode, ea_reg, 4'd4, 1'b0);
                    ext   = 3'd1 + {1'b0, ext_words(mode, ea_reg, w0[6])};
                end
                else if (w0[15:8] == 8'h40 || w0[15:8] == 8'h42 || w0[15:8] == 8'h44
                         || w0[15:8] == 8'h46 || w0[15:8] == 8'h4A) begin
                    rec_a = note(mode, ea_reg, 4'd2, 1'b0);
                    ext   = {1'b0, ext_words(mode, ea_reg, sz == 2'd2)};
                end
                else if ((w0 & MASK_HI) == OP_NBCD) begin
                    rec_a = note(mode, ea_reg, 4'd2, 1'b0);
                    ext   = {1'b0, ext_words(mode, ea_reg, 1'b0)};
                end
                else if ((w0 & MASK_CHK) == OP_CHK) begin
                    rec_a = note(mode, ea_reg, 4'd2, 1'b0);
                    ext   = {1'b0, ext_words(mode, ea_reg, 1'b0)};
                end
                else if ((w0 & MASK_LO3) == OP_LINK) begin
                    ext = 3'd1;
                end
                else if ((w0 & MASK_LO3) == OP_UNLK) begin
                    ext = 3'd0;
                end
                else if ((w0 & MASK_TRP) == OP_TRAP) begin
                    term = TERM_STOP;
                end
                else if ((w0 & MASK_LO3) == OP_MUSP) begin
                    ext = 3'd0;
                end
                else begin
                    rec_a = note(mode, ea_reg, 4'd2, 1'b0);
                    ext   = {1'b0, ext_words(mode, ea_reg, 1'b0)};
                end
            end
            LINE_QUICK:
            begin
                if ((w0 & MASK_DBC) == OP_DBCC) begin
                    term       = TERM_DBCC;
                    ext        = 3'd1;
                    has_target = 1'b1;
                    rel_target = 1'b1;
                    disp       = {{8{w1[15]}}, w1};
                end
                else begin
                    is_long = ((w0 & MASK_SCC) != OP_SCC) && (sz == 2'd2);
                    rec_a   = note(mode, ea_reg, 4'd2, 1'b0);
                    ext     = {1'b0, ext_words(mode, ea_reg, is_long)};
                end
            end
            LINE_BRANCH:
            begin
                has_target = 1'b1;
                rel_target = 1'b1;
                if (w0[7:0] == 8'h00) begin
                    ext  = 3'd1;
                    disp = {{8{w1[15]}}, w1};
                end
                else if (w0[7:0] == 8'hFF) begin
                    ext  = 3'd2;
                    disp = {w1[7:0], w2};
                end
                else begin
                    disp = {{16{w0[7]}}, w0[7:0]};
                end
                if (w0[11:8] == 4'd0) begin
                    term = TERM_BRA;
                end
                else if (w0[11:8] == 4'd1) begin
                    term = TERM_BSR;
                end
                else begin
                    term = TERM_BCC;
                end
            end
            LINE_MOVEQ:
            begin
                ext = 3'd0;
            end
            LINE_OR, LINE_SUB, LINE_CMP, LINE_AND, LINE_ADD:
            begin
                if (sz == 2'd3) begin
                    is_long = (op != LINE_OR) && (op != LINE_AND) && (dmode == 3'd7);
                end
                else begin
                    is_long = (sz == 2'd2);
                end
                rec_a = note(mode, ea_reg, 4'd2, 1'b0);
                ext   = {1'b0, ext_words(mode, ea_reg, is_long)};
            end
            LINE_SHIFT:
            begin
                if (sz == 2'd3) begin
                    rec_a = note(mode, ea_reg, 4'd2, 1'b0);
                    ext   = {1'b0, ext_words(mode, ea_reg, 1'b0)};
                end
            end
            default:
            begin
                term = TERM_UNCL;
            end
        endcase
    end

    assign rel_sum = pc + 24'd2 + disp;

    always_comb
    begin
        out0 = '{valid: 1'b0, offset: 4'd0, kind: KIND_ABS_W, is_dest: 1'b0};
        out1 = '{valid: 1'b0, offset: 4'd0, kind: KIND_ABS_W, is_dest: 1'b0};
        if (rec_a.valid) begin
            out0 = rec_a;
            if (rec_b.valid) begin
                out1 = rec_b;
            end
        end
        else if (rec_b.valid) begin
            out0 = rec_b;
        end
    end

    always_comb
    begin
        result.length_bytes  = 5'd2 + {1'b0, ext, 1'b0};
        result.term_class    = term;
        result.static_target = has_target ? {8'd0, rel_target ? rel_sum : abs_target}
                                          : NoTarget;
        result.jump_mode     = jmode;
        result.jump_reg      = jreg;
        result.record_count  = {1'b0, out0.valid} + {1'b0, out1.valid};
        result.rec0_offset   = out0.offset;
        result.rec0_kind     = out0.kind;
        result.rec0_is_dest  = out0.is_dest;
        result.rec1_offset   = out1.offset;
        result.rec1_kind     = out1.kind;
        result.rec1_is_dest  = out1.is_dest;
    end

endmodule

[dv/testbench.sv]
module testbench;
    import m68k_ilc_pkg::*;

    localparam logic [3:0] LINE_BITIMM = 4'h0;
    localparam logic [3:0] LINE_MOVE_B = 4'h1;
    localparam logic [3:0] LINE_MOVE_L = 4'h2;
    localparam logic [3:0] LINE_MOVE_W = 4'h3;
    localparam logic [3:0] LINE_MISC   = 4'h4;
    localparam logic [3:0] LINE_QUICK  = 4'h5;
    localparam logic [3:0] LINE_BRANCH = 4'h6;
    localparam logic [3:0] LINE_MOVEQ  = 4'h7;
    localparam logic [3:0] LINE_OR     = 4'h8;
    localparam logic [3:0] LINE_SUB    = 4'h9;
    localparam logic [3:0] LINE_CMP    = 4'hB;
    localparam logic [3:0] LINE_AND    = 4'hC;
    localparam logic [3:0] LINE_ADD    = 4'hD;
    localparam logic [3:0] LINE_SHIFT  = 4'hE;

    localparam logic [2:0] EA_MODE_AN  = 3'd1;
    localparam logic [2:0] EA_MODE_EXT = 3'd7;
    localparam logic [2:0] EA_ABS_W    = 3'd0;
    localparam logic [2:0] EA_ABS_L    = 3'd1;
    localparam logic [2:0] EA_PC_D16   = 3'd2;
    localparam logic [2:0] EA_PC_IDX   = 3'd3;
    localparam logic [2:0] EA_IMM      = 3'd4;

    localparam logic [15:0] OPC_ILLEGAL  = 16'h4AFC;
    localparam logic [15:0] OPC_RESET    = 16'h4E70;
    localparam logic [15:0] OPC_NOP      = 16'h4E71;
    localparam logic [15:0] OPC_STOP     = 16'h4E72;
    localparam logic [15:0] OPC_RTE      = 16'h4E73;
    localparam logic [15:0] OPC_RTD      = 16'h4E74;
    localparam logic [15:0] OPC_RTS      = 16'h4E75;
    localparam logic [15:0] OPC_TRAPV    = 16'h4E76;
    localparam logic [15:0] OPC_RTR      = 16'h4E77;
    localparam logic [15:0] OPC_JSR      = 16'h4E80;
    localparam logic [15:0] OPC_JMP      = 16'h4EC0;
    localparam logic [15:0] OPC_NBCD     = 16'h4800;
    localparam logic [15:0] OPC_SWAP     = 16'h4840;
    localparam logic [15:0] OPC_EXT_W    = 16'h4880;
    localparam logic [15:0] OPC_EXT_L    = 16'h48C0;
    localparam logic [15:0] OPC_EXTB     = 16'h49C0;
    localparam logic [15:0] OPC_LEA      = 16'h41C0;
    localparam logic [15:0] OPC_MOVEM    = 16'h4880;
    localparam logic [15:0] OPC_CHK      = 16'h4100;
    localparam logic [15:0] OPC_TRAP     = 16'h4E40;
    localparam logic [15:0] OPC_LINK     = 16'h4E50;
    localparam logic [15:0] OPC_UNLK     = 16'h4E58;
    localparam logic [15:0] OPC_MOVE_USP = 16'h4E60;
    localparam logic [15:0] OPC_SCC      = 16'h50C0;
    localparam logic [15:0] OPC_DBCC     = 16'h50C8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [ImageWidth-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [AddrWidth-1:0]  pc;
    logic [WordWidth-1:0]  word0;
    logic [WordWidth-1:0]  word1;
    logic [WordWidth-1:0]  word2;
    logic                  out_valid;
    logic                  out_stall;
    logic [4:0]            length_bytes;
    logic [3:0]            term_class;
    logic [31:0]           static_target;
    logic [2:0]            jump_mode;
    logic [2:0]            jump_reg;
    logic [1:0]            record_count;
    logic [3:0]            rec0_offset;
    logic [2:0]            rec0_kind;
    logic                  rec0_is_dest;
    logic [3:0]            rec1_offset;
    logic [2:0]            rec1_kind;
    logic                  rec1_is_dest;

    logic [ImageWidth-1:0] image_limit = ImageSizeReset;
    ilc_result_t           decoded;
    ilc_result_t           expected_q[$];
    int                    mismatches = 0;
    bit                    idle_enable = 1'b1;
    int                    hold_request = 0;
    int                    hold_left = 0;
    int                    stall_left = 0;

    m68k_instruction_length_classifier uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pc            (pc),
        .word0         (word0),
        .word1         (word1),
        .word2         (word2),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .length_bytes  (length_bytes),
        .term_class    (term_class),
        .static_target (static_target),
        .jump_mode     (jump_mode),
        .jump_reg      (jump_reg),
        .record_count  (record_count),
        .rec0_offset   (rec0_offset),
        .rec0_kind     (rec0_kind),
        .rec0_is_dest  (rec0_is_dest),
        .rec1_offset   (rec1_offset),
        .rec1_kind     (rec1_kind),
        .rec1_is_dest  (rec1_is_dest)
    );

    function automatic int unsigned operand_bytes(input logic [1:0] sz);
        return (sz == 2'd2) ? 4 : ((sz == 2'd1) ? 2 : 1);
    endfunction

    function automatic int unsigned operand_ext_count(input logic [2:0] mode,
                                                      input logic [2:0] ea_reg,
                                                      input int unsigned szb);
        if (mode <= 3'd4)
            return 0;
        if (mode <= 3'd6)
            return 1;
        case (ea_reg)
            EA_ABS_W:  return 1;
            EA_ABS_L:  return 2;
            EA_PC_D16: return 1;
            EA_PC_IDX: return 1;
            EA_IMM:    return (szb == 4) ? 2 : 1;
            default:   return 0;
        endcase
    endfunction

    function automatic void add_rebase(input int unsigned off, input kind_t kind, input logic dst);
        if (decoded.record_count == 2'd0) begin
            decoded.rec0_offset  = 4'(off);
            decoded.rec0_kind    = kind;
            decoded.rec0_is_dest = dst;
            decoded.record_count = 2'd1;
        end else if (decoded.record_count == 2'd1) begin
            decoded.rec1_offset  = 4'(off);
            decoded.rec1_kind    = kind;
            decoded.rec1_is_dest = dst;
            decoded.record_count = 2'd2;
        end
    endfunction

    function automatic void note_rebase(input logic [2:0] mode, input logic [2:0] ea_reg,
                                        input int unsigned off, input logic dst);
        if (mode != EA_MODE_EXT)
            return;
        if (ea_reg == EA_ABS_W)
            add_rebase(off, KIND_ABS_W, dst);
        else if (ea_reg == EA_ABS_L)
            add_rebase(off, KIND_ABS_L, dst);
        else if (ea_reg == EA_PC_D16)
            add_rebase(off, KIND_PCREL, 1'b0);
    endfunction

    function automatic int unsigned misc_ext_words(input logic [15:0] w0, input logic [15:0] w1,
                                                   input logic [15:0] w2);
        logic [2:0]  mode;
        logic [2:0]  ea_reg;
        logic [15:0] hi;
        logic [15:0] lo3;
        logic [15:0] b;
        logic [31:0] tgt;
        mode   = w0[5:3];
        ea_reg = w0[2:0];
        hi     = w0 & 16'hFFC0;
        lo3    = w0 & 16'hFFF8;
        b      = w0 & 16'hFF00;
        if (hi == OPC_JSR || hi == OPC_JMP) begin
            decoded.jump_mode = mode;
            decoded.jump_reg  = ea_reg;
            if (mode == EA_MODE_EXT && (ea_reg == EA_ABS_W || ea_reg == EA_ABS_L)) begin
                tgt = (ea_reg == EA_ABS_W) ? {{16{w1[15]}}, w1} : {w1, w2};
                decoded.static_target = {8'h00, tgt[23:0]};
                decoded.term_class    = w0[6] ? TERM_JMP_ABS : TERM_JSR_ABS;
            end else if (mode == EA_MODE_EXT && (ea_reg == EA_PC_D16 || ea_reg == EA_PC_IDX)) begin
                decoded.term_class = w0[6] ? TERM_JMP_PC : TERM_JSR_PC;
            end else begin
                decoded.term_class = w0[6] ? TERM_JMP_IND : TERM_JSR_IND;
            end
            return operand_ext_count(mode, ea_reg, 4);
        end
        case (w0)
            OPC_RTS: begin decoded.term_class = TERM_RTS; return 0; end
            OPC_RTR: begin decoded.term_class = TERM_RTR; return 0; end
            OPC_RTE: begin decoded.term_class = TERM_RTE; return 0; end
            OPC_RESET, OPC_TRAPV, OPC_ILLEGAL: begin decoded.term_class = TERM_STOP; return 0; end
            OPC_STOP, OPC_RTD: begin decoded.term_class = TERM_STOP; return 1; end
            OPC_NOP: return 0;
            default: ;
        endcase
        if (lo3 == OPC_SWAP || lo3 == OPC_EXT_W || lo3 == OPC_EXT_L || lo3 == OPC_EXTB)
            return 0;
        if ((w0 & 16'hF1C0) == OPC_LEA || hi == OPC_SWAP) begin
            note_rebase(mode, ea_reg, 2, 1'b0);
            return operand_ext_count(mode, ea_reg, 4);
        end
        if ((w0 & 16'hFB80) == OPC_MOVEM) begin
            note_rebase(mode, ea_reg, 4, 1'b0);
            return 1 + operand_ext_count(mode, ea_reg, w0[6] ? 4 : 2);
        end
        if (b == 16'h4000 || b == 16'h4200 || b == 16'h4400 || b == 16'h4600 || b == 16'h4A00) begin
            note_rebase(mode, ea_reg, 2, 1'b0);
            return operand_ext_count(mode, ea_reg,
                                     (w0[7:6] == 2'd3) ? 2 : operand_bytes(w0[7:6]));
        end
        if (hi == OPC_NBCD) begin
            note_rebase(mode, ea_reg, 2, 1'b0);
            return operand_ext_count(mode, ea_reg, 1);
        end
        if ((w0 & 16'hF140) == OPC_CHK) begin
            note_rebase(mode, ea_reg, 2, 1'b0);
            return operand_ext_count(mode, ea_reg, 2);
        end
        if (lo3 == OPC_LINK)
            return 1;
        if (lo3 == OPC_UNLK)
            return 0;
        if ((w0 & 16'hFFF0) == OPC_TRAP) begin
            decoded.term_class = TERM_STOP;
            return 0;
        end
        if (lo3 == OPC_MOVE_USP)
            return 0;
        note_rebase(mode, ea_reg, 2, 1'b0);
        return operand_ext_count(mode, ea_reg, 2);
    endfunction

    function automatic void predict_decode(input logic [23:0] addr, input logic [15:0] d0,
                                           input logic [15:0] d1, input logic [15:0] d2);
        logic [31:0] a32;
        logic [31:0] lim;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [3:0]  line;
        logic [2:0]  mode;
        logic [2:0]  ea_reg;
        logic [2:0]  dmode;
        logic [2:0]  dreg;
        logic [7:0]  d8;
        logic [31:0] disp;
        logic [31:0] tgt;
        int unsigned ext;
        int unsigned szb;
        int unsigned immw;
        int unsigned se;
        int unsigned len;
        a32    = {8'h00, addr};
        lim    = {7'h00, image_limit};
        w0     = (a32 + 1 >= lim) ? 16'hFFFF : d0;
        w1     = (a32 + 3 >= lim) ? 16'hFFFF : d1;
        w2     = (a32 + 5 >= lim) ? 16'hFFFF : d2;
        line   = w0[15:12];
        mode   = w0[5:3];
        ea_reg = w0[2:0];
        ext    = 0;
        decoded = '0;
        decoded.static_target = NoTarget;
        case (line)
            LINE_BITIMM: begin
                if (w0[8]) begin
                    if (mode == EA_MODE_AN) begin
                        ext = 1;
                    end else begin
                        note_rebase(mode, ea_reg, 2, 1'b0);
                        ext = operand_ext_count(mode, ea_reg, 1);
                    end
                end else if (w0[11:9] == 3'd4) begin
                    if (mode == EA_MODE_EXT && ea_reg == EA_IMM) begin
                        ext = 1;
                    end else begin
                        note_rebase(mode, ea_reg, 4, 1'b0);
                        ext = 1 + operand_ext_count(mode, ea_reg, 1);
                    end
                end else begin
                    szb  = operand_bytes(w0[7:6]);
                    immw = (szb == 4) ? 2 : 1;
                    if (mode == EA_MODE_EXT && ea_reg == EA_IMM) begin
                        ext = immw;
                    end else begin
                        note_rebase(mode, ea_reg, 2 + immw * 2, 1'b0);
                        ext = immw + operand_ext_count(mode, ea_reg, szb);
                    end
                end
            end
            LINE_MOVE_B, LINE_MOVE_L, LINE_MOVE_W: begin
                szb   = (line == LINE_MOVE_B) ? 1 : ((line == LINE_MOVE_L) ? 4 : 2);
                dmode = w0[8:6];
                dreg  = w0[11:9];
                se    = operand_ext_count(mode, ea_reg, szb);
                note_rebase(mode, ea_reg, 2, 1'b0);
                if (line != LINE_MOVE_B && dmode == EA_MODE_AN && mode == EA_MODE_EXT
                    && ea_reg == EA_IMM) begin
                    decoded.record_count = 2'd0;
                    decoded.rec0_offset  = '0;
                    decoded.rec0_kind    = KIND_ABS_W;
                    decoded.rec0_is_dest = 1'b0;
                    decoded.rec1_offset  = '0;
                    decoded.rec1_kind    = KIND_ABS_W;
                    decoded.rec1_is_dest = 1'b0;
                    add_rebase(2, (line == LINE_MOVE_L) ? KIND_IMM_L : KIND_IMM_W, 1'b0);
                end
                note_rebase(dmode, dreg, 2 + 2 * se, 1'b1);
                ext = se + operand_ext_count(dmode, dreg, szb);
            end
            LINE_MISC: ext = misc_ext_words(w0, w1, w2);
            LINE_QUICK: begin
                if ((w0 & 16'hF0F8) == OPC_DBCC) begin
                    decoded.term_class = TERM_DBCC;
                    ext = 1;
                    tgt = a32 + 2 + {{16{w1[15]}}, w1};
                    decoded.static_target = {8'h00, tgt[23:0]};
                end else begin
                    szb = ((w0 & 16'hF0C0) == OPC_SCC) ? 1 : operand_bytes(w0[7:6]);
                    note_rebase(mode, ea_reg, 2, 1'b0);
                    ext = operand_ext_count(mode, ea_reg, szb);
                end
            end
            LINE_BRANCH: begin
                d8 = w0[7:0];
                if (d8 == 8'h00) begin
                    ext  = 1;
                    disp = {{16{w1[15]}}, w1};
                end else if (d8 == 8'hFF) begin
                    ext  = 2;
                    disp = {w1, w2};
                end else begin
                    disp = {{24{d8[7]}}, d8};
                end
                tgt = a32 + 2 + disp;
                decoded.static_target = {8'h00, tgt[23:0]};
                if (w0[11:8] == 4'h0)
                    decoded.term_class = TERM_BRA;
                else if (w0[11:8] == 4'h1)
                    decoded.term_class = TERM_BSR;
                else
                    decoded.term_class = TERM_BCC;
            end
            LINE_MOVEQ: ;
            LINE_OR, LINE_SUB, LINE_CMP, LINE_AND, LINE_ADD: begin
                if (w0[7:6] == 2'd3) begin
                    if (line == LINE_OR || line == LINE_AND)
                        szb = 2;
                    else
                        szb = (w0[8:6] == 3'd7) ? 4 : 2;
                end else begin
                    szb = operand_bytes(w0[7:6]);
                end
                note_rebase(mode, ea_reg, 2, 1'b0);
                ext = operand_ext_count(mode, ea_reg, szb);
            end
            LINE_SHIFT: begin
                if (w0[7:6] == 2'd3) begin
                    note_rebase(mode, ea_reg, 2, 1'b0);
                    ext = operand_ext_count(mode, ea_reg, 2);
                end
            end
            default: decoded.term_class = TERM_UNCL;
        endcase
        len = 2 + ext * 2;
        if (len > 16) begin
            decoded.term_class = TERM_UNCL;
            len = 2;
        end
        decoded.length_bytes = 5'(len);
    endfunction

    function automatic logic [15:0] random_opcode();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 7))
            0, 1: ;
            2: w[5:0] = {EA_MODE_EXT, 3'($urandom_range(0, 4))};
            3: w[15:12] = LINE_MISC;
            4: w[15:7] = 9'h09C;
            5: begin
                w[15:7] = 9'h09D;
                if (w[0])
                    w[5:3] = EA_MODE_EXT;
            end
            6: begin
                w[15:12] = LINE_BRANCH;
                if ($urandom_range(0, 1) == 0)
                    w[7:0] = w[8] ? 8'hFF : 8'h00;
            end
            default: begin
                if (w[0]) begin
                    w[15:12] = w[1] ? LINE_MOVE_L : LINE_MOVE_W;
                    w[8:0]   = {EA_MODE_AN, EA_MODE_EXT, EA_IMM};
                end else begin
                    w[15:12] = LINE_QUICK;
                    w[7:3]   = 5'b11001;
                end
            end
        endcase
        return w;
    endfunction

    function automatic logic [23:0] random_pc();
        logic [31:0] p;
        if ($urandom_range(0, 3) == 0) begin
            p = {7'h00, image_limit} - $urandom_range(0, 8);
            return p[23:0];
        end
        return 24'($urandom);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        ilc_result_t want;
        if (expected_q.size() == 0) begin
            $error("result beat arrived with no instruction outstanding");
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        check_field("length_bytes", want.length_bytes, length_bytes);
        check_field("term_class", want.term_class, term_class);
        check_field("static_target", want.static_target, static_target);
        check_field("jump_mode", want.jump_mode, jump_mode);
        check_field("jump_reg", want.jump_reg, jump_reg);
        check_field("record_count", want.record_count, record_count);
        check_field("rec0_offset", want.rec0_offset, rec0_offset);
        check_field("rec0_kind", want.rec0_kind, rec0_kind);
        check_field("rec0_is_dest", want.rec0_is_dest, rec0_is_dest);
        check_field("rec1_offset", want.rec1_offset, rec1_offset);
        check_field("rec1_kind", want.rec1_kind, rec1_kind);
        check_field("rec1_is_dest", want.rec1_is_dest, rec1_is_dest);
    endtask

    task automatic send_instruction(input logic [23:0] addr, input logic [15:0] op,
                                    input logic [15:0] ext1, input logic [15:0] ext2);
        int gap;
        gap = idle_enable ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pc       <= addr;
        word0    <= op;
        word1    <= ext1;
        word2    <= ext2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_decode(addr, op, ext1, ext2);
        expected_q.push_back(decoded);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_image_size(input logic [ImageWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        image_limit = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_forms();
        send_instruction(24'h000000, 16'h0000, 16'h0000, 16'h0000);
        send_instruction(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_instruction(24'h000100, OPC_NOP, 16'h1234, 16'h5678);
        send_instruction(24'h000102, OPC_RTS, 16'h0000, 16'h0000);
        send_instruction(24'h000104, OPC_RTR, 16'h0000, 16'h0000);
        send_instruction(24'h000106, OPC_RTE, 16'h0000, 16'h0000);
        send_instruction(24'h000108, OPC_RESET, 16'h0000, 16'h0000);
        send_instruction(24'h00010A, OPC_STOP, 16'h2700, 16'h0000);
        send_instruction(24'h00010E, OPC_TRAP | 16'h000F, 16'h0000, 16'h0000);
        send_instruction(24'h000110, OPC_ILLEGAL, 16'h0000, 16'h0000);
        send_instruction(24'h001000, 16'h60FE, 16'h0000, 16'h0000);
        send_instruction(24'h000000, 16'h6100, 16'h8000, 16'h0000);
        send_instruction(24'hFFFFF0, 16'h66FF, 16'h0000, 16'h0020);
        send_instruction(24'h000200, OPC_DBCC | 16'h0100, 16'hFFFE, 16'h0000);
        send_instruction(24'h000300, OPC_JMP | {EA_MODE_EXT, EA_ABS_W}, 16'h8000, 16'h0000);
        send_instruction(24'h000304, OPC_JSR | {EA_MODE_EXT, EA_ABS_L}, 16'hFF12, 16'h3456);
        send_instruction(24'h00030A, OPC_JMP | {EA_MODE_EXT, EA_PC_D16}, 16'h0010, 16'h0000);
        send_instruction(24'h00030E, OPC_JSR | 16'h0010, 16'h0000, 16'h0000);
        send_instruction(24'h000310, OPC_JMP | {EA_MODE_EXT, EA_PC_IDX}, 16'h0004, 16'h0000);
        send_instruction(24'h000400, 16'h207C, 16'h00FF, 16'h1000);
        send_instruction(24'h000406, 16'h327C, 16'h2000, 16'h0000);
        send_instruction(24'h00040A, 16'h23F9, 16'h0001, 16'h0000);
        send_instruction(24'h000414, 16'h4CF9, 16'h7FFF, 16'h0001);
        send_instruction(24'h00041C, 16'hA000, 16'h0000, 16'h0000);
        send_instruction(24'h00041E, OPC_LEA | {EA_MODE_EXT, EA_PC_D16}, 16'hFFF0, 16'h0000);
        send_instruction(24'h000422, 16'h0839, 16'h0003, 16'h0001);
        send_instruction(24'h00042A, 16'hE1F9, 16'h0002, 16'h0000);
        wait_drained();
    endtask

    task automatic test_image_boundary();
        write_image_size(25'h0000100);
        send_instruction(24'h0000FA, OPC_JSR | {EA_MODE_EXT, EA_ABS_L}, 16'h0012, 16'h3456);
        send_instruction(24'h0000FC, OPC_JSR | {EA_MODE_EXT, EA_ABS_L}, 16'h0012, 16'h3456);
        send_instruction(24'h0000FE, OPC_JSR | {EA_MODE_EXT, EA_ABS_L}, 16'h0012, 16'h3456);
        send_instruction(24'h000100, OPC_NOP, 16'h0000, 16'h0000);
        wait_drained();
        write_image_size(25'h0000000);
        send_instruction(24'h000000, OPC_NOP, 16'h0000, 16'h0000);
        send_instruction(24'h123456, 16'h6000, 16'h0010, 16'h0000);
        wait_drained();
        write_image_size(ImageSizeReset);
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so the
    // pipeline fills and the input stalls; then the sender waits for every result.
    task automatic test_backpressure();
        idle_enable = 1'b0;
        hold_request = 120;
        for (int i = 0; i < 40; i++)
            send_instruction(random_pc(), random_opcode(), 16'($urandom), 16'($urandom));
        wait_drained();
        idle_enable = 1'b1;
    endtask

    task automatic test_random_stream();
        logic [ImageWidth-1:0] sizes[4];
        sizes[0] = ImageSizeReset;
        sizes[1] = ImageWidth'($urandom_range(2, 64));
        sizes[2] = ImageWidth'($urandom_range(0, 32'h1000000));
        sizes[3] = ImageSizeReset;
        for (int s = 0; s < 4; s++) begin
            wait_drained();
            write_image_size(sizes[s]);
            for (int i = 0; i < 300; i++) begin
                if (i % 60 == 0)
                    idle_enable = ($urandom_range(0, 3) != 0);
                send_instruction(random_pc(), random_opcode(), 16'($urandom), 16'($urandom));
            end
        end
        wait_drained();
        idle_enable = 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                check_result();
                stall_left = idle_enable ? $urandom_range(0, 12) : 0;
            end
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        pc        <= '0;
        word0     <= '0;
        word1     <= '0;
        word2     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_forms();
        test_image_boundary();
        test_backpressure();
        test_random_stream();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
